// ----- src/aou_pkg.sv -----
// Shared types and constants for the adaptive optimizer update unit.
package aou_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int FRAC_BITS = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE       = 3'd0,
		REG_DECAY_OLD  = 3'd1,
		REG_WEIGHT_NEW = 3'd2,
		REG_STEP_SIZE  = 3'd3,
		REG_EPS_FLOOR  = 3'd4
	} reg_idx_t;

	localparam logic        MODE_RMSPROP = 1'b0;
	localparam logic        MODE_ADAM    = 1'b1;
	localparam logic [24:0] DECAY_RST    = 25'd15099494;
	localparam logic [24:0] WEIGHT_RST   = 25'd1677722;
	localparam logic [24:0] STEP_RST     = 25'd16777;
	localparam logic [15:0] EPS_RST      = 16'd2;

	// Width of the square-root radicand (ms << F) and the root.
	localparam int RAD_W  = 62;
	localparam int ROOT_W = 31;
	// Magnitude of step * x: 25 + 32 bits.
	localparam int NUM_W  = 57;
	// Divisor: root plus epsilon (Adam) or the larger of root and epsilon (RMSprop).
	localparam int DIV_W  = 32;

	// Digit-by-digit square root state handed from cell to cell.
	typedef struct packed {
		logic [RAD_W-1:0]  rem;
		logic [ROOT_W:0]   root;
	} sqrt_t;

	// Restoring divider state handed from cell to cell.
	typedef struct packed {
		logic [DIV_W:0]    rem;
		logic [NUM_W-1:0]  num;
	} div_t;

	// Item fields that travel alongside the iterative cells.
	typedef struct packed {
		logic signed [31:0] param;
		logic signed [31:0] x;
		logic signed [31:0] moment;
		logic [30:0]        ms;
		logic               last;
		logic               mode;
		logic [15:0]        eps;
		logic [24:0]        step;
	} side_t;

endpackage

// ----- src/aou_sqrt_cell.sv -----
// One cell of the square-root chain: settles one root bit per cycle while en is high.
module aou_sqrt_cell #(
	parameter int BIT = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  aou_pkg::sqrt_t   d_in,
	input  aou_pkg::side_t   side_in,
	output logic             vld_out,
	output aou_pkg::sqrt_t   d_out,
	output aou_pkg::side_t   side_out
);
	import aou_pkg::*;

	logic [RAD_W:0] trial;
	logic [RAD_W:0] rem_ext;
	sqrt_t          nxt;

	always_comb begin
		rem_ext = {1'b0, d_in.rem};
		trial   = ({{(RAD_W-ROOT_W){1'b0}}, d_in.root} << (BIT + 1))
			| ({{RAD_W{1'b0}}, 1'b1} << (2 * BIT));
		nxt = d_in;
		if (rem_ext >= trial) begin
			nxt.rem  = RAD_W'(rem_ext - trial);
			nxt.root = d_in.root | ({{ROOT_W{1'b0}}, 1'b1} << BIT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out    <= nxt;
			side_out <= side_in;
		end
	end

endmodule

// ----- src/aou_div_cell.sv -----
// One cell of the divider chain: settles one quotient bit per cycle while en is high.
module aou_div_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_in,
	input  logic [aou_pkg::DIV_W-1:0]     den,
	input  aou_pkg::div_t                 d_in,
	input  aou_pkg::side_t                side_in,
	output logic                          vld_out,
	output logic [aou_pkg::DIV_W-1:0]     den_out,
	output aou_pkg::div_t                 d_out,
	output aou_pkg::side_t                side_out
);
	import aou_pkg::*;

	logic [DIV_W+1:0] shifted;
	div_t             nxt;

	always_comb begin
		shifted = {d_in.rem, d_in.num[NUM_W-1]};
		nxt.num = {d_in.num[NUM_W-2:0], 1'b0};
		if (shifted >= {2'b00, den}) begin
			nxt.rem    = (DIV_W+1)'(shifted - {2'b00, den});
			nxt.num[0] = 1'b1;
		end else begin
			nxt.rem = (DIV_W+1)'(shifted);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out    <= nxt;
			den_out  <= den;
			side_out <= side_in;
		end
	end

endmodule

// ----- src/adaptive_optimizer_update_unit.sv -----
// Top level of the adaptive optimizer update unit (RMSprop and Adam).
// The unit takes one weight element per cycle while not stalled and returns one result per element in order,
// after three product and sum stages, 31 square-root cells that each
// settle one root bit, two setup stages, 57 divider cells that each settle one quotient bit,
// and one output stage. All stages advance together; the whole chain holds while a finished
// result waits at the output and the input side is stalled only then.
module adaptive_optimizer_update_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [aou_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [31:0]            param_in,
	input  logic signed [31:0]            grad,
	input  logic signed [31:0]            moment_in,
	input  logic [30:0]                   mean_square_in,
	input  logic                          last_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            param_out,
	output logic signed [31:0]            moment_out,
	output logic [30:0]                   mean_square_out,
	output logic                          last_out
);
	import aou_pkg::*;

	localparam int NSQ = ROOT_W;
	localparam int NDV = NUM_W;

	logic        mode_q;
	logic [24:0] decay_q, weight_q, step_q;
	logic [15:0] eps_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_RMSPROP;
			decay_q  <= DECAY_RST;
			weight_q <= WEIGHT_RST;
			step_q   <= STEP_RST;
			eps_q    <= EPS_RST;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_MODE:       mode_q   <= cfg_data[0];
				REG_DECAY_OLD:  decay_q  <= cfg_data[24:0];
				REG_WEIGHT_NEW: weight_q <= cfg_data[24:0];
				REG_STEP_SIZE:  step_q   <= cfg_data[24:0];
				REG_EPS_FLOOR:  eps_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	logic acc;
	assign acc = in_valid && in_ready;

	// Stage 1: gradient square, moment products.
	logic        v_s1;
	logic [63:0] gsq_s1;
	logic signed [58:0] km_s1, kg_s1;
	side_t       sd_s1;
	logic [31:0] gabs;
	assign gabs = grad[31] ? 32'(-grad) : grad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= acc;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			gsq_s1 <= 64'(gabs) * 64'(gabs);
			km_s1  <= $signed({1'b0, decay_q}) * 59'(moment_in);
			kg_s1  <= $signed({1'b0, weight_q}) * 59'(grad);
			sd_s1  <= '{param: param_in, x: grad, moment: moment_in, ms: mean_square_in,
				last: last_in, mode: mode_q, eps: eps_q, step: step_q};
		end
	end

	// Stage 2: mean-square products and new moment.
	logic        v_s2;
	logic [63:0] a_s2, b_s2;
	side_t       sd_s2;
	side_t       sd_n2;
	logic [63:0] g2;
	logic signed [59:0] msum;
	logic signed [35:0] mflr;
	logic signed [31:0] mnew;
	assign g2   = gsq_s1 >> FRAC_BITS;
	assign msum = 60'(km_s1) + 60'(kg_s1);
	assign mflr = 36'(msum >>> FRAC_BITS);
	assign mnew = (mflr > 36'sd2147483647) ? 32'sh7fffffff
		: (mflr < -36'sd2147483648) ? 32'sh80000000 : mflr[31:0];

	function automatic logic [63:0] mul_sat(input logic [24:0] a, input logic [63:0] b);
		logic [88:0] p;
		p = 89'(a) * 89'(b);
		mul_sat = (p > 89'(64'h4000000000000000)) ? 64'h4000000000000000 : p[63:0];
	endfunction

	always_comb begin
		sd_n2 = sd_s1;
		if (sd_s1.mode == MODE_ADAM) begin
			sd_n2.moment = mnew;
			sd_n2.x      = mnew;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			a_s2  <= mul_sat(decay_q, 64'(sd_s1.ms));
			b_s2  <= mul_sat(weight_q, g2);
			sd_s2 <= sd_n2;
		end
	end

	// Stage 3: new mean square.
	logic        v_s3;
	sqrt_t       sq_s3;
	side_t       sd_s3;
	side_t       sd_n3;
	logic [63:0] msacc;
	logic [63:0] msh;
	logic [30:0] msn;
	assign msacc = a_s2 + b_s2;
	assign msh   = msacc >> FRAC_BITS;
	assign msn   = (msh > 64'h7fffffff) ? 31'h7fffffff : msh[30:0];

	always_comb begin
		sd_n3    = sd_s2;
		sd_n3.ms = msn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3.rem  <= RAD_W'({31'b0, msn} << FRAC_BITS);
			sq_s3.root <= '0;
			sd_s3      <= sd_n3;
		end
	end

	// Square-root chain.
	logic  sv [NSQ+1];
	sqrt_t sq [NSQ+1];
	side_t ss [NSQ+1];
	assign sv[0] = v_s3;
	assign sq[0] = sq_s3;
	assign ss[0] = sd_s3;

	for (genvar i = 0; i < NSQ; i++) begin : g_sq
		aou_sqrt_cell #(.BIT(NSQ - 1 - i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(sv[i]), .d_in(sq[i]), .side_in(ss[i]),
			.vld_out(sv[i+1]), .d_out(sq[i+1]), .side_out(ss[i+1])
		);
	end

	// Setup stage: divisor and numerator magnitude.
	logic             v_s4;
	logic [DIV_W-1:0] den_s4;
	logic signed [57:0] num_s4;
	side_t            sd_s4;
	logic [DIV_W-1:0] rt, ep, dsel;
	assign rt   = DIV_W'(sq[NSQ].root);
	assign ep   = DIV_W'(ss[NSQ].eps);
	assign dsel = (ss[NSQ].mode == MODE_ADAM) ? DIV_W'(rt + ep) : ((rt > ep) ? rt : ep);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= sv[NSQ];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			den_s4 <= (dsel == '0) ? DIV_W'(1) : dsel;
			num_s4 <= $signed({1'b0, ss[NSQ].step}) * 58'(ss[NSQ].x);
			sd_s4  <= ss[NSQ];
		end
	end

	logic             v_s5;
	logic [DIV_W-1:0] den_s5;
	div_t             dv_s5;
	side_t            sd_s5;
	side_t            sd_n5;

	always_comb begin
		sd_n5   = sd_s4;
		sd_n5.x = {31'b0, num_s4[57]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			den_s5     <= den_s4;
			dv_s5.rem  <= '0;
			dv_s5.num  <= NUM_W'(num_s4[57] ? -num_s4 : num_s4);
			sd_s5      <= sd_n5;
		end
	end

	// Divider chain.
	logic             dv [NDV+1];
	logic [DIV_W-1:0] dn [NDV+1];
	div_t             dd [NDV+1];
	side_t            ds [NDV+1];
	assign dv[0] = v_s5;
	assign dn[0] = den_s5;
	assign dd[0] = dv_s5;
	assign ds[0] = sd_s5;

	for (genvar j = 0; j < NDV; j++) begin : g_dv
		aou_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(dv[j]), .den(dn[j]), .d_in(dd[j]), .side_in(ds[j]),
			.vld_out(dv[j+1]), .den_out(dn[j+1]), .d_out(dd[j+1]), .side_out(ds[j+1])
		);
	end

	// Output stage.
	logic signed [58:0] q, pn;
	assign q  = ds[NDV].x[0] ? -59'(dd[NDV].num) : 59'(dd[NDV].num);
	assign pn = 59'(ds[NDV].param) - q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= dv[NDV];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			param_out <= (pn > 59'sd2147483647) ? 32'sh7fffffff
				: (pn < -59'sd2147483648) ? 32'sh80000000 : pn[31:0];
			moment_out      <= ds[NDV].moment;
			mean_square_out <= ds[NDV].ms;
			last_out        <= ds[NDV].last;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(param_out))
		else $error("result dropped while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");
	a_den: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> den_s5 != '0)
		else $error("zero divisor");

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the adaptive optimizer update unit (RMSprop and Adam modes).
`timescale 1ns / 1ps

module tb_top;
	import aou_pkg::*;

	localparam longint unsigned MS_MAX   = 64'h7FFF_FFFF;
	localparam longint unsigned PROD_CAP = 64'h1 << 62;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		logic signed [31:0] param;
		logic signed [31:0] moment;
		logic [30:0]        ms;
		logic               last;
	} update_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] param_in = '0;
	logic signed [31:0] grad = '0;
	logic signed [31:0] moment_in = '0;
	logic [30:0] mean_square_in = '0;
	logic last_in = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] param_out;
	logic signed [31:0] moment_out;
	logic [30:0] mean_square_out;
	logic last_out;

	// Shadow copy of the configuration registers.
	logic        opt_mode = MODE_RMSPROP;
	logic [24:0] k_old = DECAY_RST;
	logic [24:0] k_new = WEIGHT_RST;
	logic [24:0] lr = STEP_RST;
	logic [15:0] eps = EPS_RST;

	update_t pending_updates[$];
	int mismatches = 0;
	int cycles = 0;
	int stall_hold = 0;
	bit steady_sink = 1'b0;

	adaptive_optimizer_update_unit uut (.*);

	always #5 clk = ~clk;

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned r = 0;
		longint unsigned b = 64'h1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint clamp_s32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic update_t compute_update(logic signed [31:0] p, logic signed [31:0] g,
			logic signed [31:0] m, logic [30:0] ms, logic last);
		longint sp = p;
		longint sg = g;
		longint sm = m;
		longint unsigned gabs, g2, t1, t2, msn, root, d, mag, q;
		longint mn, x, num, delta;
		update_t r;
		gabs = (sg < 0) ? -sg : sg;
		g2 = (gabs * gabs) >> 24;
		t1 = longint'(k_old) * longint'(ms);
		t2 = longint'(k_new) * g2;
		if (t1 > PROD_CAP)
			t1 = PROD_CAP;
		if (t2 > PROD_CAP)
			t2 = PROD_CAP;
		msn = (t1 + t2) >> 24;
		if (msn > MS_MAX)
			msn = MS_MAX;
		root = isqrt(msn << 24);
		if (opt_mode == MODE_ADAM) begin
			mn = clamp_s32((longint'(k_old) * sm + longint'(k_new) * sg) >>> 24);
			x = mn;
			d = root + eps;
		end else begin
			mn = sm;
			x = sg;
			d = (root > eps) ? root : eps;
		end
		if (d == 0)
			d = 1;
		num = longint'(lr) * x;
		mag = (num < 0) ? -num : num;
		q = mag / d;
		delta = (num < 0) ? -longint'(q) : longint'(q);
		r.param = 32'(clamp_s32(sp - delta));
		r.moment = 32'(mn);
		r.ms = msn[30:0];
		r.last = last;
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		mismatches++;
		$display("MISMATCH %s: got %0d, expected %0d at cycle %0d", what, got, want, cycles);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Result checker.
	always @(posedge clk) begin
		update_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_updates.size() == 0) begin
				report("unexpected beat", 1, 0);
			end else begin
				want = pending_updates.pop_front();
				if (param_out !== want.param)
					report("param_out", param_out, want.param);
				if (moment_out !== want.moment)
					report("moment_out", moment_out, want.moment);
				if (mean_square_out !== want.ms)
					report("mean_square_out", mean_square_out, want.ms);
				if (last_out !== want.last)
					report("last_out", last_out, want.last);
			end
		end
	end

	// Receiver back-pressure: mostly short stalls, a few long ones.
	always @(negedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (steady_sink) begin
			out_ready <= 1'b1;
		end else if (stall_hold > 0) begin
			out_ready <= 1'b0;
			stall_hold <= stall_hold - 1;
		end else if (r < 70) begin
			out_ready <= 1'b1;
		end else if (r < 97) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b0;
			stall_hold <= $urandom_range(10, 60);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Called at a falling edge; returns at a falling edge.
	task automatic send_elem(logic signed [31:0] p, logic signed [31:0] g,
			logic signed [31:0] m, logic [30:0] ms, logic last, int gap);
		in_valid <= 1'b1;
		param_in <= p;
		grad <= g;
		moment_in <= m;
		mean_square_in <= ms;
		last_in <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_updates.insert(pending_updates.size(), compute_update(p, g, m, ms, last));
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_updates.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Called at a falling edge while the unit is idle; leaves cfg_valid high.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_MODE:       opt_mode = data[0];
			REG_DECAY_OLD:  k_old = data[24:0];
			REG_WEIGHT_NEW: k_new = data[24:0];
			REG_STEP_SIZE:  lr = data[24:0];
			REG_EPS_FLOOR:  eps = data[15:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_config(logic md, logic [31:0] k1, logic [31:0] k2, logic [31:0] st,
			logic [31:0] e);
		drain();
		write_reg(REG_MODE, {31'd0, md});
		write_reg(REG_DECAY_OLD, k1);
		write_reg(REG_WEIGHT_NEW, k2);
		write_reg(REG_STEP_SIZE, st);
		write_reg(REG_EPS_FLOOR, e);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return '0;
			default: return ($urandom_range(0, 1) ? -1 : 1) * int'($urandom_range(0, 32'h0400_0000));
		endcase
	endfunction

	task automatic edge_values();
		send_elem(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, 0);
		send_elem(-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000, 31'h7FFF_FFFF, 1'b0, 1);
		send_elem('0, '0, '0, '0, 1'b0, 0);
		send_elem(32'sh0100_0000, 32'sh0100_0000, -32'sh0100_0000, 31'h0100_0000, 1'b1, 2);
		send_elem(-32'sh0100_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0, 1'b0, 0);
		send_elem(32'sh7FFF_FFFF, -32'sh8000_0000, '0, '0, 1'b1, 0);
		send_elem(-32'sh8000_0000, 32'sh7FFF_FFFF, '0, '0, 1'b0, 0);
		send_elem(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 31'h2AAA_AAAA, 1'b1, 0);
	endtask

	task automatic test_reset_config();
		edge_values();
		drain();
	endtask

	task automatic test_adam_directed();
		set_config(MODE_ADAM, 32'd15099494, 32'd1677722, 32'd16777, 32'd2);
		edge_values();
	endtask

	task automatic test_zero_eps();
		set_config(MODE_RMSPROP, 32'd0, 32'd0, 32'd16777216, 32'd0);
		send_elem(32'sh0100_0000, 32'sh0000_1000, 32'sh0000_0040, 31'd5, 1'b0, 0);
		send_elem(32'sh0100_0000, -32'sh8000_0000, '0, 31'd5, 1'b1, 0);
		set_config(MODE_ADAM, 32'd0, 32'd0, 32'd16777216, 32'd0);
		send_elem(32'sh0100_0000, 32'sh0000_1000, 32'sh1234_5678, 31'd5, 1'b0, 0);
		send_elem(-32'sh0100_0000, -32'sh8000_0000, -32'sh1234_5678, '0, 1'b1, 0);
	endtask

	task automatic test_large_coeffs();
		set_config(MODE_ADAM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		edge_values();
		set_config(MODE_RMSPROP, 32'd16777216, 32'd16777216, 32'd16777216, 32'd65535);
		edge_values();
	endtask

	task automatic test_unused_index();
		drain();
		write_reg(REG_UNUSED_LO, 32'hFFFF_FFFF);
		write_reg(REG_UNUSED_HI, 32'h0000_0000);
		cfg_valid <= 1'b0;
		send_elem(32'sh0100_0000, 32'sh0080_0000, 32'sh0040_0000, 31'h0100_0000, 1'b1, 0);
	endtask

	task automatic test_random(int count);
		int n;
		for (int ph = 0; ph < 8; ph++) begin
			set_config(1'($urandom_range(0, 1)),
				$urandom_range(0, 2) == 0 ? $urandom() : $urandom_range(14000000, 16777216),
				$urandom_range(0, 2) == 0 ? $urandom() : $urandom_range(0, 3000000),
				$urandom_range(0, 2) == 0 ? $urandom() : $urandom_range(0, 200000),
				$urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 64));
			steady_sink = (ph == 3);
			n = count / 8;
			for (int i = 0; i < n; i++) begin
				send_elem(rand_word(), rand_word(), rand_word(), 31'(rand_word()),
					1'($urandom_range(0, 1)), (ph == 3) ? 0 : pick_gap());
				if (i == n / 2 && ph == 5)
					drain();
			end
		end
		steady_sink = 1'b0;
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_config();
		test_adam_directed();
		test_zero_eps();
		test_large_coeffs();
		test_unused_index();
		test_random(1840);
		drain();
		repeat (120) @(negedge clk);
		if (mismatches == 0 && pending_updates.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- adaptive_optimizer_update_unit.f -----
src/aou_pkg.sv
src/aou_sqrt_cell.sv
src/aou_div_cell.sv
src/adaptive_optimizer_update_unit.sv
sim/tb_top.sv
